// File: hw/rtl/fct_pkg.sv
// Package for the frustum cull test unit: op codes, plane layout, plane count.
// No dependencies.
package fct_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int COEF_W      = 16;
    localparam int FRAC_SHIFT  = 14;
    localparam int RADIUS_W    = 15;

    typedef enum logic [2:0] {
        OP_POINT   = 3'd0,
        OP_RAY     = 3'd1,
        OP_SPHERE  = 3'd2,
        OP_CUBE    = 3'd3,
        OP_BOX_HALF = 3'd4,
        OP_BOX_MM  = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        REG_NEAR   = 3'd0,
        REG_FAR    = 3'd1,
        REG_LEFT   = 3'd2,
        REG_RIGHT  = 3'd3,
        REG_TOP    = 3'd4,
        REG_BOTTOM = 3'd5
    } t_reg_idx;

    localparam int FIRST_SIDE_PLANE = 2;

endpackage

// File: hw/rtl/frustum_cull_test_unit.sv
// Top level of the frustum cull test unit: APB plane registers, input prep,
// six plane evaluators and the result skid. Depends on fct_pkg, fct_plane_eval.
//
// Usage: software writes six 64-bit planes over the APB port (register i at
// byte address 8*i; a = [15:0], b = [31:16], c = [47:32] Q1.14, d = [63:48]
// Q15.0). Each input word on the valid/ready channel carries an op code and
// a primitive; one output word with visible follows for every input word.
// An input word passes from acceptance to o_valid through five register stages
// (input prep, products, partial sums, corner compares, final reduction).
// Throughput: one word per cycle while the receiver does not stall; the datapath
// is a five-stage pipeline with valid bits per stage.
// When the receiver stalls the whole pipeline holds; o_ready drops only when
// the output register is full and not being taken, so nothing is lost or
// repeated. Reset clears all planes to zero (every defined op visible) and empties
// the pipeline.
module frustum_cull_test_unit
    import fct_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [2:0]                    i_op,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_ext_x,
    input  logic signed [COORD_WIDTH-1:0] i_ext_y,
    input  logic signed [COORD_WIDTH-1:0] i_ext_z,
    input  logic [RADIUS_W-1:0]           i_radius,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_visible
);
    localparam int CW = COORD_WIDTH;
    // Internal coordinate width: wide enough for the radius and the plane offset
    localparam int XW = (CW > 16) ? CW : 16;
    localparam int NST = 5;

    // Plane registers
    logic [63:0] r_plane [PLANE_COUNT];
    logic [2:0]  reg_idx;
    assign reg_idx = paddr[5:3];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_COUNT; i++) r_plane[i] <= '0;
        end else if (psel && penable && pwrite && reg_idx < 3'(PLANE_COUNT)) begin
            r_plane[reg_idx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx < 3'(PLANE_COUNT)) prdata = r_plane[reg_idx];
    end

    // Pipeline control: advance when the output slot is free or being taken
    logic       adv;
    logic [NST-1:0] r_vld;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end
    assign o_valid = r_vld[NST-1];

    // Stage 0: build corner bounds and the sphere limit
    logic signed [XW:0] n_lo [3], n_hi [3];
    logic signed [XW:0] r_lo [3], r_hi [3];
    logic signed [XW:0] p [3], e [3], rr;
    logic signed [XW+FRAC_SHIFT+1:0] r_lim;
    logic [2:0] r_op [4];

    assign p[0] = (XW+1)'(i_pos_x); assign p[1] = (XW+1)'(i_pos_y);
    assign p[2] = (XW+1)'(i_pos_z);
    assign e[0] = (XW+1)'(i_ext_x); assign e[1] = (XW+1)'(i_ext_y);
    assign e[2] = (XW+1)'(i_ext_z);
    assign rr   = (XW+1)'($signed({1'b0, i_radius}));

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            case (i_op)
                OP_RAY: begin
                    n_lo[j] = p[j] + e[j];
                    n_hi[j] = p[j] + e[j];
                end
                OP_CUBE: begin
                    n_lo[j] = p[j] - rr;
                    n_hi[j] = p[j] + rr;
                end
                OP_BOX_HALF: begin
                    n_lo[j] = p[j] - e[j];
                    n_hi[j] = p[j] + e[j];
                end
                OP_BOX_MM: begin
                    n_lo[j] = p[j];
                    n_hi[j] = e[j];
                end
                default: begin
                    n_lo[j] = p[j];
                    n_hi[j] = p[j];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int j = 0; j < 3; j++) begin
                r_lo[j] <= n_lo[j];
                r_hi[j] <= n_hi[j];
            end
            r_lim    <= -((XW+FRAC_SHIFT+2)'($signed({1'b0, i_radius})) <<< FRAC_SHIFT);
            r_op[0]  <= i_op;
            for (int s = 1; s < 4; s++) r_op[s] <= r_op[s-1];
        end
    end

    // Stages 1..3: one evaluator per plane
    logic [PLANE_COUNT-1:0] any_ge, lo_ge, lo_ge_lim;
    for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_plane
        fct_plane_eval #(.CW(XW)) u_eval (
            .i_clk      (i_clk),
            .i_en       (adv),
            .i_plane    (r_plane[g]),
            .i_lo_x     (r_lo[0]),
            .i_lo_y     (r_lo[1]),
            .i_lo_z     (r_lo[2]),
            .i_hi_x     (r_hi[0]),
            .i_hi_y     (r_hi[1]),
            .i_hi_z     (r_hi[2]),
            .i_lim      (r_lim),
            .o_any_ge   (any_ge[g]),
            .o_lo_ge    (lo_ge[g]),
            .o_lo_ge_lim(lo_ge_lim[g])
        );
    end

    // Stage 4: reduce per op into the output register
    logic n_vis;
    always_comb begin
        case (r_op[3])
            OP_POINT:  n_vis = &lo_ge;
            OP_RAY:    n_vis = &lo_ge[PLANE_COUNT-1:FIRST_SIDE_PLANE];
            OP_SPHERE: n_vis = &lo_ge_lim;
            OP_CUBE, OP_BOX_HALF, OP_BOX_MM: n_vis = &any_ge;
            default:   n_vis = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) o_visible <= n_vis;
    end
endmodule

// File: hw/rtl/fct_plane_eval.sv
// One plane of the cull test: products, sums and per-corner sign tests, pipelined.
// Depends on fct_pkg.
module fct_plane_eval
    import fct_pkg::*;
#(
    parameter int CW = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [63:0]         i_plane,
    input  logic signed [CW:0]  i_lo_x,
    input  logic signed [CW:0]  i_lo_y,
    input  logic signed [CW:0]  i_lo_z,
    input  logic signed [CW:0]  i_hi_x,
    input  logic signed [CW:0]  i_hi_y,
    input  logic signed [CW:0]  i_hi_z,
    input  logic signed [CW+FRAC_SHIFT+1:0] i_lim,
    output logic                o_any_ge,
    output logic                o_lo_ge,
    output logic                o_lo_ge_lim
);
    localparam int PW = CW + COEF_W + 1;
    localparam int DW = PW + 3;

    logic signed [COEF_W-1:0] a, b, c, d;
    assign a = i_plane[15:0];
    assign b = i_plane[31:16];
    assign c = i_plane[47:32];
    assign d = i_plane[63:48];

    // Stage A: six products and the offset
    logic signed [PW-1:0] r_ax_lo, r_ax_hi, r_by_lo, r_by_hi, r_cz_lo, r_cz_hi;
    logic signed [DW-1:0] r_d, r_lim_a;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ax_lo <= PW'(a * i_lo_x);
            r_ax_hi <= PW'(a * i_hi_x);
            r_by_lo <= PW'(b * i_lo_y);
            r_by_hi <= PW'(b * i_hi_y);
            r_cz_lo <= PW'(c * i_lo_z);
            r_cz_hi <= PW'(c * i_hi_z);
            r_d     <= DW'(d) <<< FRAC_SHIFT;
            r_lim_a <= DW'(i_lim);
        end
    end

    // Stage B: partial sums for all xy combinations, z terms with offset
    logic signed [DW-1:0] r_xy [4];
    logic signed [DW-1:0] r_zd [2];
    logic signed [DW-1:0] r_lim_b;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xy[0] <= DW'(r_ax_lo) + DW'(r_by_lo);
            r_xy[1] <= DW'(r_ax_hi) + DW'(r_by_lo);
            r_xy[2] <= DW'(r_ax_lo) + DW'(r_by_hi);
            r_xy[3] <= DW'(r_ax_hi) + DW'(r_by_hi);
            r_zd[0] <= DW'(r_cz_lo) + r_d;
            r_zd[1] <= DW'(r_cz_hi) + r_d;
            r_lim_b <= r_lim_a;
        end
    end

    // Stage C: eight corner distances, sign tests reduced
    logic [7:0] ge;
    logic signed [DW-1:0] corner_dist [8];
    always_comb begin
        for (int k = 0; k < 8; k++) begin
            corner_dist[k] = r_xy[k % 4] + r_zd[k / 4];
            ge[k]          = (corner_dist[k] >= 0);
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_any_ge    <= |ge;
            o_lo_ge     <= ge[0];
            o_lo_ge_lim <= (corner_dist[0] >= r_lim_b);
        end
    end
endmodule

// File: sim/fct_checker.sv
// Checker for the frustum cull test unit: mirrors the plane registers from the
// APB port, predicts visibility per input word and compares output words.
// Depends on fct_pkg.
module fct_checker
    import fct_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    input  logic                          pready,
    input  logic                          i_valid,
    input  logic                          o_ready,
    input  logic [2:0]                    i_op,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_ext_x,
    input  logic signed [COORD_WIDTH-1:0] i_ext_y,
    input  logic signed [COORD_WIDTH-1:0] i_ext_z,
    input  logic [RADIUS_W-1:0]           i_radius,
    input  logic                          o_valid,
    input  logic                          i_ready,
    input  logic                          o_visible,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [63:0] plane_copy [PLANE_COUNT];
    bit          visible_q [$];

    // Plane distance with 14 fraction bits
    function automatic longint plane_dist(int i, longint x, longint y, longint z);
        longint a, b, c, d;
        a = longint'($signed(plane_copy[i][15:0]));
        b = longint'($signed(plane_copy[i][31:16]));
        c = longint'($signed(plane_copy[i][47:32]));
        d = longint'($signed(plane_copy[i][63:48]));
        return a * x + b * y + c * z + (d <<< FRAC_SHIFT);
    endfunction

    // Reject when some plane has all eight corners outside
    function automatic bit box_visible(longint lx, longint ly, longint lz,
                                       longint hx, longint hy, longint hz);
        bit any_in;
        for (int i = 0; i < PLANE_COUNT; i++) begin
            any_in = 0;
            for (int k = 0; k < 8; k++) begin
                if (plane_dist(i, k[0] ? hx : lx, k[1] ? hy : ly, k[2] ? hz : lz) >= 0)
                    any_in = 1;
            end
            if (!any_in) return 0;
        end
        return 1;
    endfunction

    function automatic bit predict_visible();
        longint px, py, pz, ex, ey, ez, r;
        bit     vis;
        px = i_pos_x; py = i_pos_y; pz = i_pos_z;
        ex = i_ext_x; ey = i_ext_y; ez = i_ext_z;
        r  = longint'(i_radius);
        vis = 0;
        case (i_op)
            OP_POINT: begin
                vis = 1;
                for (int i = 0; i < PLANE_COUNT; i++)
                    if (plane_dist(i, px, py, pz) < 0) vis = 0;
            end
            OP_RAY: begin
                vis = 1;
                for (int i = FIRST_SIDE_PLANE; i < PLANE_COUNT; i++)
                    if (plane_dist(i, px + ex, py + ey, pz + ez) < 0) vis = 0;
            end
            OP_SPHERE: begin
                vis = 1;
                for (int i = 0; i < PLANE_COUNT; i++)
                    if (plane_dist(i, px, py, pz) < -(r <<< FRAC_SHIFT)) vis = 0;
            end
            OP_CUBE:     vis = box_visible(px - r, py - r, pz - r, px + r, py + r, pz + r);
            OP_BOX_HALF: vis = box_visible(px - ex, py - ey, pz - ez,
                                           px + ex, py + ey, pz + ez);
            OP_BOX_MM:   vis = box_visible(px, py, pz, ex, ey, ez);
            default:     vis = 0;
        endcase
        return vis;
    endfunction

    // Track planes, queue predictions, compare output words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PLANE_COUNT; i++) plane_copy[i] = '0;
            visible_q.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
        end else begin
            if (i_valid && o_ready)
                visible_q.push_back(predict_visible());
            if (o_valid && i_ready) begin
                if (visible_q.size() == 0) begin
                    $error("visible: no word expected, actual %0d", o_visible);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    bit exp_vis;
                    exp_vis = visible_q.pop_front();
                    if (exp_vis !== o_visible) begin
                        $error("visible: expected %0d actual %0d", exp_vis, o_visible);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= visible_q.size();
            if (psel && penable && pwrite && pready && (paddr[5:3] < PLANE_COUNT))
                plane_copy[paddr[5:3]] = pwdata;
        end
    end

endmodule

// File: sim/tb_top.sv
// Testbench top for the frustum cull test unit: clock, reset, plane writes,
// primitive stimulus, receiver stalls and verdict. Depends on fct_pkg, fct_checker.
module tb_top;
    import fct_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 16;

    logic                 i_clk, i_rst_n;
    logic                 psel, penable, pwrite, pready;
    logic [5:0]           paddr;
    logic [63:0]          pwdata, prdata;
    logic                 i_valid, o_ready, o_valid, i_ready, o_visible;
    logic [2:0]           i_op;
    logic signed [CW-1:0] i_pos_x, i_pos_y, i_pos_z, i_ext_x, i_ext_y, i_ext_z;
    logic [RADIUS_W-1:0]  i_radius;
    int                   fail_count, pending;
    logic                 in_taken;
    bit                   hold_req;

    frustum_cull_test_unit #(.COORD_WIDTH(CW)) uut (.*);

    fct_checker #(.COORD_WIDTH(CW)) chk (
        .*, .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // Acceptance seen at the last rising edge
    always @(posedge i_clk) in_taken <= i_valid && o_ready;

    // Receiver: stall patterns, plus one long hold-off on request
    initial begin
        int mode;
        i_ready = 0;
        mode = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_ready = 0;
                repeat (300) @(negedge i_clk);
                hold_req = 0;
            end else begin
                if ($urandom_range(63) == 0) mode = $urandom_range(3);
                case (mode)
                    0: i_ready = 1;
                    1: i_ready = $urandom_range(1);
                    2: i_ready = ($urandom_range(3) == 0);
                    default: i_ready = ($urandom_range(7) != 0);
                endcase
            end
        end
    end

    initial begin
        #2ms;
        $display("FAIL frustum_cull_test_unit");
        $finish;
    end

    task automatic plane_write(int idx, logic [63:0] val);
        @(negedge i_clk);
        psel = 1; penable = 0; pwrite = 1; paddr = 6'(idx * 8); pwdata = val;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // Wait for the pipeline to drain before touching planes
    task automatic drain();
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_planes(logic [63:0] p0, p1, p2, p3, p4, p5);
        drain();
        plane_write(REG_NEAR, p0);
        plane_write(REG_FAR, p1);
        plane_write(REG_LEFT, p2);
        plane_write(REG_RIGHT, p3);
        plane_write(REG_TOP, p4);
        plane_write(REG_BOTTOM, p5);
    endtask

    // Offer one word and hold it until taken; called at a falling edge
    task automatic send_word(logic [2:0] op, logic [15:0] px, py, pz, ex, ey, ez,
                             logic [14:0] r);
        i_valid = 1; i_op = op;
        i_pos_x = px; i_pos_y = py; i_pos_z = pz;
        i_ext_x = ex; i_ext_y = ey; i_ext_z = ez; i_radius = r;
        do @(negedge i_clk); while (!in_taken);
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(3))
            0: return 16'($urandom);
            default: return 16'($signed($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic logic [63:0] rand_plane();
        return {16'($signed($urandom_range(4096)) - 2048), 16'($urandom), 16'($urandom),
                16'($urandom)};
    endfunction

    task automatic random_burst(int count);
        int n, gap;
        logic [2:0] op;
        n = 0;
        while (n < count) begin
            for (int b = $urandom_range(1, 16); b > 0 && n < count; b--) begin
                op = ($urandom_range(15) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(5));
                send_word(op, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                          rand_coord(), rand_coord(),
                          ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(256)));
                n++;
            end
            gap = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid = 0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_valid = 0;
    endtask

    task automatic directed_set();
        for (int op = 0; op < 8; op++) begin
            send_word(3'(op), 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                      15'h7FFF);
            send_word(3'(op), 16'h8000, 16'h7FFF, 16'h0000, 16'hFFF0, 16'h0010, 16'h8000,
                      15'h0000);
        end
        // Negative half-sizes and min above max
        send_word(OP_BOX_HALF, 16'h0100, 16'h0100, 16'h0100, 16'hFF00, 16'hFF00, 16'hFF00,
                  15'h0000);
        send_word(OP_BOX_MM, 16'h0200, 16'h0200, 16'h0200, 16'hFE00, 16'hFE00, 16'hFE00,
                  15'h0000);
        i_valid = 0;
    endtask

    initial begin
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        i_valid = 0; i_op = '0; i_radius = '0; hold_req = 0;
        i_pos_x = '0; i_pos_y = '0; i_pos_z = '0;
        i_ext_x = '0; i_ext_y = '0; i_ext_z = '0;
        i_rst_n = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1;

        // All-zero planes after reset: every defined op reports visible
        directed_set();

        set_planes(64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                   64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF,
                   64'h7FFF_7FFF_7FFF_7FFF, 64'h7FFF_7FFF_7FFF_7FFF);
        directed_set();
        set_planes(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                   64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                   64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000);
        directed_set();
        drain();
        plane_write(6, 64'hFFFF_FFFF_FFFF_FFFF);
        plane_write(7, 64'h1234_5678_9ABC_DEF0);
        random_burst(100);

        for (int ph = 0; ph < 7; ph++) begin
            set_planes(rand_plane(), rand_plane(), rand_plane(),
                       rand_plane(), rand_plane(), rand_plane());
            @(negedge i_clk);
            if (ph == 2) hold_req = 1;
            random_burst(170);
        end

        set_planes(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        random_burst(60);

        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS frustum_cull_test_unit");
        else
            $display("FAIL frustum_cull_test_unit");
        $finish;
    end

endmodule
